// ===== rtl/shabs_pkg.sv =====
// shared types and constants for the sha-1 byte stream hasher
// no dependencies; used by shabs_ctrl, shabs_dp and the top level
`default_nettype none

package shabs_pkg;

   // controller states, one-hot
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_PAD   = 5'b00010,
      ST_ROUND = 5'b00100,
      ST_FOLD  = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   // source of the byte shifted into the block buffer
   typedef enum logic [1:0] {
      SEL_DATA  = 2'd0,
      SEL_PAD80 = 2'd1,
      SEL_ZERO  = 2'd2,
      SEL_LEN   = 2'd3
   } byte_sel_type;

   // commands from controller to datapath
   typedef struct packed {
      logic         load_byte;
      byte_sel_type byte_sel;
      logic [2:0]   len_idx;
      logic         count_inc;
      logic         round_start;
      logic         round_step;
      logic [1:0]   round_grp;
      logic         fold;
      logic         reinit;
      logic [2:0]   out_idx;
   } ctrl_cmd_type;

   localparam logic [3:0][31:0] RoundK = {
      32'hca62c1d6, 32'h8f1bbcdc, 32'h6ed9eba1, 32'h5a827999
   };

   localparam logic [4:0][31:0] InitChain = {
      32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
   };

   localparam logic [7:0] PadByte      = 8'h80;
   localparam logic [5:0] LenStartFill = 6'd56;
   localparam logic [5:0] LastFill     = 6'd63;
   localparam logic [6:0] LastRound    = 7'd79;
   localparam logic [6:0] GrpOneStart  = 7'd20;
   localparam logic [6:0] GrpTwoStart  = 7'd40;
   localparam logic [6:0] GrpThreeStart = 7'd60;
   localparam logic [2:0] LastWordIdx  = 3'd4;

endpackage

`default_nettype wire

// ===== rtl/shabs_ctrl.sv =====
// controller for the sha-1 hasher: byte fill, padding sequence, rounds, digest output
// depends on shabs_pkg
`default_nettype none

module shabs_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic                   req_op,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [2:0]                  rsp_word_index,
   output logic                        rsp_last_word,
   output shabs_pkg::ctrl_cmd_type     cmd
);

   shabs_pkg::state_type state_ff, state_in;
   logic [5:0] fill_ff, fill_in;
   logic [6:0] rnd_ff, rnd_in;
   logic       pad_first_ff, pad_first_in;
   logic       pad_active_ff, pad_active_in;
   logic       len_phase_ff, len_phase_in;
   logic [2:0] out_idx_ff, out_idx_in;
   logic       ld;

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      rnd_in        = rnd_ff;
      pad_first_in  = pad_first_ff;
      pad_active_in = pad_active_ff;
      len_phase_in  = len_phase_ff;
      out_idx_in    = out_idx_ff;
      ld            = 1'b0;
      req_ready     = 1'b0;
      rsp_valid     = 1'b0;

      cmd.load_byte   = 1'b0;
      cmd.byte_sel    = shabs_pkg::SEL_DATA;
      cmd.len_idx     = fill_ff[2:0];
      cmd.count_inc   = 1'b0;
      cmd.round_start = 1'b0;
      cmd.round_step  = 1'b0;
      cmd.fold        = 1'b0;
      cmd.reinit      = 1'b0;
      cmd.out_idx     = out_idx_ff;
      if (rnd_ff < shabs_pkg::GrpOneStart) begin
         cmd.round_grp = 2'd0;
      end else if (rnd_ff < shabs_pkg::GrpTwoStart) begin
         cmd.round_grp = 2'd1;
      end else if (rnd_ff < shabs_pkg::GrpThreeStart) begin
         cmd.round_grp = 2'd2;
      end else begin
         cmd.round_grp = 2'd3;
      end

      case (state_ff)
         shabs_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_op) begin
                  state_in      = shabs_pkg::ST_PAD;
                  pad_first_in  = 1'b1;
                  pad_active_in = 1'b1;
               end else begin
                  ld            = 1'b1;
                  cmd.count_inc = 1'b1;
                  cmd.byte_sel  = shabs_pkg::SEL_DATA;
               end
            end
         end
         shabs_pkg::ST_PAD: begin
            ld = 1'b1;
            if (pad_first_ff) begin
               cmd.byte_sel = shabs_pkg::SEL_PAD80;
               pad_first_in = 1'b0;
            end else if (len_phase_ff || fill_ff == shabs_pkg::LenStartFill) begin
               cmd.byte_sel = shabs_pkg::SEL_LEN;
               len_phase_in = 1'b1;
            end else begin
               cmd.byte_sel = shabs_pkg::SEL_ZERO;
            end
         end
         shabs_pkg::ST_ROUND: begin
            cmd.round_step = 1'b1;
            rnd_in = rnd_ff + 7'd1;
            if (rnd_ff == shabs_pkg::LastRound) begin
               state_in = shabs_pkg::ST_FOLD;
            end
         end
         shabs_pkg::ST_FOLD: begin
            cmd.fold = 1'b1;
            if (len_phase_ff) begin
               state_in   = shabs_pkg::ST_OUT;
               out_idx_in = 3'd0;
            end else if (pad_active_ff) begin
               state_in = shabs_pkg::ST_PAD;
            end else begin
               state_in = shabs_pkg::ST_IDLE;
            end
         end
         shabs_pkg::ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (out_idx_ff == shabs_pkg::LastWordIdx) begin
                  // digest delivered: back to the initial chaining state
                  cmd.reinit    = 1'b1;
                  state_in      = shabs_pkg::ST_IDLE;
                  pad_active_in = 1'b0;
                  len_phase_in  = 1'b0;
                  fill_in       = 6'd0;
               end else begin
                  out_idx_in = out_idx_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = shabs_pkg::ST_IDLE;
         end
      endcase

      // every byte shifted in advances the fill; a full block starts the rounds
      if (ld) begin
         cmd.load_byte = 1'b1;
         fill_in = fill_ff + 6'd1;
         if (fill_ff == shabs_pkg::LastFill) begin
            state_in        = shabs_pkg::ST_ROUND;
            cmd.round_start = 1'b1;
            rnd_in          = 7'd0;
         end
      end
   end

   assign rsp_word_index = out_idx_ff;
   assign rsp_last_word  = (out_idx_ff == shabs_pkg::LastWordIdx);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= shabs_pkg::ST_IDLE;
         fill_ff       <= 6'd0;
         rnd_ff        <= 7'd0;
         pad_first_ff  <= 1'b0;
         pad_active_ff <= 1'b0;
         len_phase_ff  <= 1'b0;
         out_idx_ff    <= 3'd0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         rnd_ff        <= rnd_in;
         pad_first_ff  <= pad_first_in;
         pad_active_ff <= pad_active_in;
         len_phase_ff  <= len_phase_in;
         out_idx_ff    <= out_idx_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/shabs_dp.sv =====
// datapath for the sha-1 hasher: block shift buffer, message schedule, round unit,
// chaining words and byte counter; depends on shabs_pkg
`default_nettype none

module shabs_dp (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire shabs_pkg::ctrl_cmd_type cmd,
   input  wire logic [7:0]              req_data_byte,
   output logic [31:0]                  rsp_digest_word
);

   // block buffer: first byte of the block sits in the top bits
   logic [511:0]      blk_ff, blk_in;
   logic [4:0][31:0]  h_ff, h_in;
   logic [31:0]       a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0]       a_in, b_in, c_in, d_in, e_in;
   logic [31:0]       count_ff, count_in;
   logic [63:0]       len_bits;
   logic [7:0]        byte_val;
   logic [31:0]       w0, w_mix, w_new, f_val, t_val;

   assign len_bits = {29'd0, count_ff, 3'd0};

   always_comb begin
      case (cmd.byte_sel)
         shabs_pkg::SEL_DATA:  byte_val = req_data_byte;
         shabs_pkg::SEL_PAD80: byte_val = shabs_pkg::PadByte;
         shabs_pkg::SEL_ZERO:  byte_val = 8'd0;
         shabs_pkg::SEL_LEN:   byte_val = len_bits[8 * (7 - cmd.len_idx) +: 8];
         default:              byte_val = 8'd0;
      endcase
   end

   // schedule: w0 is W[i], w_new is W[i+16]
   assign w0    = blk_ff[511:480];
   assign w_mix = blk_ff[447:416] ^ blk_ff[255:224] ^ blk_ff[95:64] ^ w0;
   assign w_new = {w_mix[30:0], w_mix[31]};

   always_comb begin
      case (cmd.round_grp)
         2'd0:    f_val = d_ff ^ (b_ff & (c_ff ^ d_ff));
         2'd2:    f_val = (b_ff & c_ff) | (d_ff & (b_ff | c_ff));
         default: f_val = b_ff ^ c_ff ^ d_ff;
      endcase
   end

   assign t_val = f_val + shabs_pkg::RoundK[cmd.round_grp] + {a_ff[26:0], a_ff[31:27]}
                  + e_ff + w0;

   always_comb begin
      blk_in   = blk_ff;
      h_in     = h_ff;
      count_in = count_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      d_in     = d_ff;
      e_in     = e_ff;
      if (cmd.load_byte) begin
         blk_in = {blk_ff[503:0], byte_val};
      end
      if (cmd.count_inc) begin
         count_in = count_ff + 32'd1;
      end
      if (cmd.round_start) begin
         a_in = h_ff[0];
         b_in = h_ff[1];
         c_in = h_ff[2];
         d_in = h_ff[3];
         e_in = h_ff[4];
      end
      if (cmd.round_step) begin
         blk_in = {blk_ff[479:0], w_new};
         a_in   = t_val;
         b_in   = a_ff;
         c_in   = {b_ff[1:0], b_ff[31:2]};
         d_in   = c_ff;
         e_in   = d_ff;
      end
      if (cmd.fold) begin
         h_in[0] = h_ff[0] + a_ff;
         h_in[1] = h_ff[1] + b_ff;
         h_in[2] = h_ff[2] + c_ff;
         h_in[3] = h_ff[3] + d_ff;
         h_in[4] = h_ff[4] + e_ff;
      end
      if (cmd.reinit) begin
         h_in     = shabs_pkg::InitChain;
         count_in = 32'd0;
      end
   end

   assign rsp_digest_word = h_ff[cmd.out_idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         h_ff     <= shabs_pkg::InitChain;
         count_ff <= 32'd0;
      end else begin
         h_ff     <= h_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      c_ff   <= c_in;
      d_ff   <= d_in;
      e_ff   <= e_in;
   end

endmodule

`default_nettype wire

// ===== rtl/sha1_byte_stream_hasher.sv =====
// top level of the sha-1 byte stream hasher
// depends on shabs_pkg, shabs_ctrl and shabs_dp
`default_nettype none

// sha-1 over a byte stream, one request per message byte plus one finish request
// - req channel: req_op 0 adds req_data_byte to the message, req_op 1 finishes it
// - rsp channel: five transfers per finish, digest words 0..4 most significant first,
//   rsp_last_word marks word 4
// - a data byte is taken while idle; the byte that completes a 64-byte block
//   is followed by 80 rounds, one per cycle, and then the chaining add
// - sustained rate for long messages is set by the single round unit in the
//   datapath: no new byte is taken while a block is compressed
// - finish: padding bytes are shifted in one per cycle outside compressions (9 to
//   72 of them), with one or two compressions, then the digest words are offered
// - req_ready is low while a block is compressed, padding runs or the digest is out
// - a stalled receiver holds the digest word, index and last flag; nothing moves
//   until the word is taken
// - after the fifth word is taken the chaining words and byte count return to
//   their initial values and the next message can start
// - reset (synchronous, active high) gives the idle state with the initial
//   chaining words; no clearing pass is needed
module sha1_byte_stream_hasher (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_op,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_digest_word,
   output logic [2:0]       rsp_word_index,
   output logic             rsp_last_word
);

   shabs_pkg::ctrl_cmd_type cmd;

   // sequencing: byte fill, padding order, round count, digest word index
   shabs_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_word_index (rsp_word_index),
      .rsp_last_word  (rsp_last_word),
      .cmd            (cmd)
   );

   // block buffer, schedule, rounds and chaining words
   shabs_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_data_byte   (req_data_byte),
      .rsp_digest_word (rsp_digest_word)
   );

endmodule

`default_nettype wire

// ===== rtl/shabs_checker.sv =====
// port-level checks for the sha-1 byte stream hasher, bound to the top level
// depends only on the top level's ports
`default_nettype none

module shabs_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_digest_word,
   input wire logic [2:0]  rsp_word_index,
   input wire logic        rsp_last_word
);

   // no new request is taken while the digest is being delivered
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && req_ready))
      else $error("req_ready high while digest is offered");

   // last flag marks exactly word four
   a_last_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_word == (rsp_word_index == 3'd4)))
      else $error("last flag does not match word index");

   // digest words come back to back in index order
   a_index_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_word) |=>
         (rsp_valid && rsp_word_index == $past(rsp_word_index) + 3'd1))
      else $error("digest word index did not advance");

   // stalled digest word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_digest_word) && $stable(rsp_word_index)))
      else $error("digest word changed while stalled");

   // after the last word the block is ready for the next message
   a_ready_after: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last_word) |=> req_ready)
      else $error("not ready after digest delivered");

endmodule

bind sha1_byte_stream_hasher shabs_checker u_shabs_checker (.*);

`default_nettype wire

// ===== dv/sha1_byte_stream_hasher_test.sv =====
// self-checking testbench for sha1_byte_stream_hasher: byte and finish requests in,
// digest words out, checked against a behavioral sha-1 predictor kept in this file
// depends on shabs_pkg (chaining init values, round constants, pad byte) and the rtl top

module sha1_byte_stream_hasher_test;

   // request op codes
   localparam logic OpAddByte = 1'b0;
   localparam logic OpFinish  = 1'b1;

   localparam int QuietLimit = 4000;   // cycles with no transfer on either channel
   localparam int HoldCycles = 300;    // long receiver hold-off in the pressure phase
   localparam int DrainCycles = 100;   // settle time after the last digest word

   typedef struct packed {
      logic       op;
      logic [7:0] data_byte;
   } hash_req_type;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_word_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_op = OpAddByte;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   hash_req_type    pending_items[$];
   digest_word_type digest_expected[$];

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_request = 0;     // bumped by the stimulus to start a hold-off
   int hold_seen = 0;
   int hold_left = 0;
   int quiet_cycles = 0;
   int fail_count = 0;

   // predictor state
   logic [31:0] msg_words[16];
   logic [31:0] chain[5];
   logic [31:0] msg_bytes;
   logic [5:0]  block_fill;

   sha1_byte_stream_hasher dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   task automatic sha_restart();
      for (int i = 0; i < 16; i++) msg_words[i] = 32'h0;
      for (int i = 0; i < 5; i++) chain[i] = shabs_pkg::InitChain[i];
      msg_bytes = 32'h0;
      block_fill = 6'd0;
   endtask

   // 80 rounds over the buffered block, then fold into the chaining words
   task automatic sha_compress();
      logic [31:0] w[16];
      logic [31:0] a, b, c, d, e, f, t;
      w = msg_words;
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      e = chain[4];
      for (int i = 0; i < 80; i++) begin
         if (i >= 16) begin
            t = w[(i + 13) & 15] ^ w[(i + 8) & 15] ^ w[(i + 2) & 15] ^ w[i & 15];
            w[i & 15] = {t[30:0], t[31]};
         end
         if (i < 20) f = d ^ (b & (c ^ d));
         else if (i < 40) f = b ^ c ^ d;
         else if (i < 60) f = (b & c) | (d & (b | c));
         else f = b ^ c ^ d;
         t = f + shabs_pkg::RoundK[i / 20] + {a[26:0], a[31:27]} + e + w[i & 15];
         e = d;
         d = c;
         c = {b[1:0], b[31:2]};
         b = a;
         a = t;
      end
      chain[0] = chain[0] + a;
      chain[1] = chain[1] + b;
      chain[2] = chain[2] + c;
      chain[3] = chain[3] + d;
      chain[4] = chain[4] + e;
   endtask

   // big-endian packing into the block buffer
   task automatic sha_absorb(input logic [7:0] value);
      int lane;
      lane = block_fill[1:0];
      msg_words[block_fill[5:2]][8 * (3 - lane) +: 8] = value;
      block_fill = block_fill + 6'd1;
      if (block_fill == 6'd0) sha_compress();
   endtask

   // applies one accepted request; a finish queues the five digest words
   task automatic hash_request(input hash_req_type item);
      logic [63:0] bit_len;
      if (item.op == OpAddByte) begin
         msg_bytes = msg_bytes + 32'd1;
         sha_absorb(item.data_byte);
      end else begin
         bit_len = {32'h0, msg_bytes} << 3;
         sha_absorb(shabs_pkg::PadByte);
         while (block_fill != shabs_pkg::LenStartFill) sha_absorb(8'h00);
         for (int k = 0; k < 8; k++) sha_absorb(bit_len[63 - 8 * k -: 8]);
         for (int k = 0; k < 5; k++)
            digest_expected.push_back('{word: chain[k], index: 3'(k),
                                        last: (k == 4)});
         sha_restart();
      end
   endtask

   // ---------------------------------------------------------------- driver

   // offers the next pending item, idling at random per phase
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            hash_req_type item;
            item = pending_items.pop_front();
            req_valid <= 1'b1;
            req_op <= item.op;
            req_data_byte <= item.data_byte;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_request != hold_seen) begin
         hold_seen <= hold_request;
         hold_left <= HoldCycles;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // ---------------------------------------------------------------- monitor

   // predicts on each request transfer, checks each digest transfer in order
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            hash_request('{op: req_op, data_byte: req_data_byte});
         if (rsp_valid && rsp_ready) begin
            if (digest_expected.size() == 0) begin
               $error("unexpected digest transfer: word %h index %0d last %0b",
                      rsp_digest_word, rsp_word_index, rsp_last_word);
               fail_count++;
            end else begin
               digest_word_type want;
               want = digest_expected.pop_front();
               if (rsp_digest_word !== want.word) begin
                  $error("digest_word: expected %h, got %h", want.word, rsp_digest_word);
                  fail_count++;
               end
               if (rsp_word_index !== want.index) begin
                  $error("word_index: expected %0d, got %0d", want.index, rsp_word_index);
                  fail_count++;
               end
               if (rsp_last_word !== want.last) begin
                  $error("last_word: expected %0b, got %0b", want.last, rsp_last_word);
                  fail_count++;
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
      end
   end

   // watchdog
   initial begin
      while (quiet_cycles < QuietLimit) @(negedge clock);
      $display("== FAIL ==");
      $finish;
   end

   // ---------------------------------------------------------------- stimulus

   task automatic push_item(input logic op, input logic [7:0] value);
      pending_items.push_back('{op: op, data_byte: value});
   endtask

   // a message of len random bytes closed by a finish
   task automatic push_message(input int len);
      int r;
      for (int i = 0; i < len; i++) begin
         r = $urandom_range(15);
         if (r == 0) push_item(OpAddByte, 8'h00);
         else if (r == 1) push_item(OpAddByte, 8'hff);
         else push_item(OpAddByte, 8'($urandom_range(255)));
      end
      // the byte on a finish must be ignored, so keep it random
      push_item(OpFinish, 8'($urandom_range(255)));
   endtask

   // short random messages; block and pad boundaries are covered by directed ones
   task automatic push_random_messages(input int item_goal, input int finish_goal);
      int items;
      int finishes;
      int len;
      items = 0;
      finishes = 0;
      while (items < item_goal || finishes < finish_goal) begin
         len = $urandom_range(12);
         push_message(len);
         items += len + 1;
         finishes++;
      end
   endtask

   task automatic set_idling(input int send_pct, input int stall_pct);
      @(negedge clock);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
   endtask

   // block is idle once every item is taken and every digest word has come back
   task automatic wait_drained();
      @(negedge clock);
      while (pending_items.size() != 0 || req_valid || digest_expected.size() != 0)
         @(negedge clock);
   endtask

   initial begin
      sha_restart();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: empty message, "abc", byte extremes, ignored finish byte
      set_idling(0, 0);
      push_item(OpFinish, 8'hff);
      push_item(OpAddByte, 8'h61);
      push_item(OpAddByte, 8'h62);
      push_item(OpAddByte, 8'h63);
      push_item(OpFinish, 8'h00);
      push_item(OpAddByte, 8'h00);
      push_item(OpAddByte, 8'hff);
      push_item(OpFinish, 8'h5a);
      push_item(OpAddByte, 8'hff);
      push_item(OpFinish, 8'hff);
      push_item(OpFinish, 8'h00);
      // a full block from data bytes alone, padding then in a fresh block
      push_message(64);
      wait_drained();

      // sender idling
      set_idling(58, 0);
      push_random_messages(4, 1);
      wait_drained();

      // receiver stalling
      set_idling(0, 58);
      push_random_messages(4, 1);
      wait_drained();

      // both sides idling
      set_idling(18, 18);
      push_random_messages(4, 1);
      wait_drained();

      // receiver holds off while requests keep coming, so the input backs up;
      // the second message spills its padding into a second block
      set_idling(0, 0);
      push_message(3);
      push_message(56);
      push_message(0);
      hold_request = hold_request + 1;
      wait_drained();

      repeat (DrainCycles) @(negedge clock);
      if (fail_count == 0 && digest_expected.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
